// File: rtl/trie_sequence_transcoder_assert.svh
// Assertion macros for the trie sequence transcoder checker.
`ifndef TRIE_SEQUENCE_TRANSCODER_ASSERT_SVH
`define TRIE_SEQUENCE_TRANSCODER_ASSERT_SVH

// Same-cycle implication.
`define TST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tst check failed");

// Next-cycle implication.
`define TST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tst check failed");

`endif

// File: rtl/tst_pkg.sv
// Package: types and constants for the trie sequence transcoder.
package tst_pkg;
	localparam logic [2:0] MODE_WR_NODE  = 3'd0;
	localparam logic [2:0] MODE_WR_SLOT  = 3'd1;
	localparam logic [2:0] MODE_WR_SEQ   = 3'd2;
	localparam logic [2:0] MODE_DECODE   = 3'd3;
	localparam logic [2:0] MODE_FLUSH    = 3'd4;
	localparam logic [2:0] MODE_SET      = 3'd5;
	localparam logic [2:0] MODE_READ     = 3'd6;

	localparam int NODES       = 8192;
	localparam int CHILD_SLOTS = 8192;
	localparam int SEQ_WORDS   = 32768;
	localparam logic [3:0] MAX_SEQ = 4'd8;

	typedef struct packed {
		logic [2:0]  mode;
		logic [20:0] code;
		logic [12:0] node_index;
		logic [14:0] slot_index;
		logic [15:0] repl_code;
		logic [12:0] child_first;
		logic [7:0]  child_count;
		logic [14:0] seq_first;
		logic [3:0]  seq_count;
	} cmd_t;

	typedef struct packed {
		logic [20:0] out_code;
		logic        last;
		logic        kind;
		logic        status;
		logic [12:0] state_index;
	} res_t;

	// repl, child_first, child_count, seq_first, seq_count
	typedef struct packed {
		logic [15:0] repl;
		logic [12:0] cf;
		logic [7:0]  cc;
		logic [14:0] sf;
		logic [3:0]  sc;
	} node_t;
endpackage

// File: rtl/trie_sequence_transcoder.sv
// Top level: trie sequence transcoder with memory-resident node, slot and word tables.
// Writes finish on the accepting edge; a read/set report is strobed the cycle after.
//   Decode: reads node info, scans the children (slot, then label); a miss at a non-root node
//   emits its replacement or word sequence and adds a root pass; a root miss echoes the code.
// One transaction at a time while busy; results strobed by res_valid, no stall.
// Reset clears control state and the config registers; tables are undefined until written.
module trie_sequence_transcoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tst_pkg::cmd_t      cmd,
	output logic               res_valid,
	output tst_pkg::res_t      res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import tst_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_INFO_RD = 9'b000000010,
		ST_INFO = 9'b000000100,
		ST_SCAN = 9'b000001000,
		ST_SLOT = 9'b000010000,
		ST_LABEL = 9'b000100000,
		ST_EMIT = 9'b001000000,
		ST_SEQ = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	// Tables
	node_t       node_mem  [NODES];
	logic [15:0] label_mem [NODES];
	logic [12:0] child_mem [CHILD_SLOTS];
	logic [15:0] seq_mem   [SEQ_WORDS];

	node_t       node_rd_q;
	logic [15:0] label_rd_q;
	logic [12:0] child_rd_q;
	logic [15:0] seq_rd_q;

	state_t      state_q;
	logic [12:0] root_q;
	logic [13:0] ncount_q;
	logic [12:0] cur_q;
	logic [12:0] node_q;
	logic        nonroot_q;
	logic        flush_q;
	logic [20:0] code_q;
	node_t       info_q;
	logic [7:0]  i_q;
	logic [3:0]  j_q;

	logic        pend_valid_q;
	logic [20:0] pend_q;
	logic        res_valid_q;
	res_t        res_q;

	logic        accept;
	logic        cfg_wr;
	logic [13:0] slot_sum;
	logic [15:0] seq_sum;
	logic [3:0]  seq_n;

	assign accept   = start && (state_q == ST_IDLE);
	assign cfg_wr   = psel && penable && pwrite;
	assign slot_sum = {1'b0, info_q.cf} + {6'd0, i_q};
	assign seq_sum  = {1'b0, info_q.sf} + {12'd0, j_q};
	assign seq_n    = (info_q.sc > MAX_SEQ) ? MAX_SEQ : info_q.sc;

	assign busy      = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? {18'd0, ncount_q} : {19'd0, root_q};

	// Table writes happen on the accepting edge; reads are registered every cycle.
	always_ff @(posedge clk) begin
		if (accept && cmd.mode == MODE_WR_NODE) begin
			node_mem[cmd.node_index] <= '{repl: cmd.repl_code, cf: cmd.child_first,
				cc: cmd.child_count, sf: cmd.seq_first, sc: cmd.seq_count};
			label_mem[cmd.node_index] <= cmd.code[15:0];
		end
		if (accept && cmd.mode == MODE_WR_SLOT && !cmd.slot_index[13] && !cmd.slot_index[14])
			child_mem[cmd.slot_index[12:0]] <= cmd.node_index;
		if (accept && cmd.mode == MODE_WR_SEQ)
			seq_mem[cmd.slot_index] <= cmd.code[15:0];
		node_rd_q  <= node_mem[node_q];
		child_rd_q <= child_mem[slot_sum[12:0]];
		label_rd_q <= label_mem[child_rd_q];
		seq_rd_q   <= seq_mem[seq_sum[14:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_q       <= '0;
			ncount_q     <= '0;
			cur_q        <= '0;
			node_q       <= '0;
			nonroot_q    <= 1'b0;
			flush_q      <= 1'b0;
			code_q       <= '0;
			info_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2]) ncount_q <= pwdata[13:0];
				else root_q <= pwdata[12:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						code_q <= cmd.code;
						case (cmd.mode)
							MODE_DECODE: begin
								node_q    <= cur_q;
								nonroot_q <= (cur_q != root_q);
								flush_q   <= 1'b0;
								state_q   <= ST_INFO_RD;
							end
							MODE_FLUSH: begin
								if (cur_q != root_q) begin
									node_q  <= cur_q;
									flush_q <= 1'b1;
									state_q <= ST_INFO_RD;
								end
								cur_q <= root_q;
							end
							MODE_SET: begin
								res_valid_q <= 1'b1;
								res_q <= '{out_code: '0, last: 1'b1, kind: 1'b1,
									status: ({1'b0, cmd.node_index} >= ncount_q),
									state_index: cur_q};
								if ({1'b0, cmd.node_index} < ncount_q)
									cur_q <= cmd.node_index;
							end
							MODE_READ: begin
								res_valid_q <= 1'b1;
								res_q <= '{out_code: '0, last: 1'b1, kind: 1'b1,
									status: 1'b0, state_index: cur_q};
							end
							default: ;
						endcase
					end
				end
				ST_INFO_RD: state_q <= ST_INFO;
				ST_INFO: begin
					info_q  <= node_rd_q;
					i_q     <= '0;
					j_q     <= '0;
					state_q <= flush_q ? ST_EMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (i_q == info_q.cc || slot_sum[13]) begin
						if (nonroot_q) begin
							state_q <= ST_EMIT;
						end else begin
							// miss at root: echo the code point
							if (pend_valid_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{out_code: pend_q, last: 1'b0, kind: 1'b0,
									status: 1'b0, state_index: '0};
							end
							pend_valid_q <= 1'b1;
							pend_q       <= code_q;
							state_q      <= ST_DONE;
						end
					end else begin
						state_q <= ST_SLOT;
					end
				end
				ST_SLOT: state_q <= ST_LABEL;
				ST_LABEL: begin
					if ({5'd0, label_rd_q} == code_q) begin
						cur_q   <= child_rd_q;
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + 8'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (info_q.repl != '0 || j_q == seq_n) begin
						if (info_q.repl != '0) begin
							if (pend_valid_q) begin
								res_valid_q <= 1'b1;
								res_q <= '{out_code: pend_q, last: 1'b0, kind: 1'b0,
									status: 1'b0, state_index: '0};
							end
							pend_valid_q <= 1'b1;
							pend_q       <= {5'd0, info_q.repl};
						end
						if (flush_q) begin
							state_q <= ST_DONE;
						end else begin
							// retry the same code point from the root
							cur_q     <= root_q;
							node_q    <= root_q;
							nonroot_q <= 1'b0;
							state_q   <= ST_INFO_RD;
						end
					end else begin
						state_q <= ST_SEQ;
					end
				end
				ST_SEQ: begin
					if (pend_valid_q) begin
						res_valid_q <= 1'b1;
						res_q <= '{out_code: pend_q, last: 1'b0, kind: 1'b0,
							status: 1'b0, state_index: '0};
					end
					pend_valid_q <= 1'b1;
					pend_q       <= seq_sum[15] ? 21'd0 : {5'd0, seq_rd_q};
					j_q          <= j_q + 4'd1;
					state_q      <= ST_EMIT;
				end
				ST_DONE: begin
					if (pend_valid_q) begin
						res_valid_q <= 1'b1;
						res_q <= '{out_code: pend_q, last: 1'b1, kind: 1'b0,
							status: 1'b0, state_index: '0};
					end
					pend_valid_q <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/tst_checker.sv
// Port-level checker for the trie sequence transcoder, with its bind.
`include "trie_sequence_transcoder_assert.svh"
module tst_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input tst_pkg::cmd_t cmd,
	input logic          res_valid,
	input tst_pkg::res_t res,
	input logic          pready
);
	import tst_pkg::*;

	`TST_ASSERT_NEXT(a_decode_busy, start && !busy && cmd.mode == MODE_DECODE, busy)
	`TST_ASSERT_NEXT(a_report_next, start && !busy && cmd.mode == MODE_READ, res_valid && res.kind)
	`TST_ASSERT_NOW(a_report_last, res_valid && res.kind, res.last)
	`TST_ASSERT_NOW(a_code_clean, res_valid && !res.kind, !res.status && res.state_index == '0)
	`TST_ASSERT_NOW(a_ready, 1'b1, pready)
endmodule

bind trie_sequence_transcoder tst_checker u_tst_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.res_valid(res_valid), .res(res), .pready(pready)
);

// File: dv/trie_sequence_transcoder_test.sv
// Self-checking testbench for the trie sequence transcoder (directed edges, random trie walks).
module trie_sequence_transcoder_test;
	import tst_pkg::*;

	// Mode 7 has no function and gives no result.
	localparam logic [2:0] MODE_NONE = 3'd7;
	// Register addresses on the APB port.
	localparam logic [2:0] ADDR_ROOT   = 3'd0;
	localparam logic [2:0] ADDR_NCOUNT = 3'd4;

	// Small pool that the random part keeps well formed, so a walk never
	// reaches a table entry that was never loaded.
	localparam int POOL_NODES = 16;
	localparam int POOL_SLOTS = 32;
	localparam int POOL_WORDS = 64;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        res_valid;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	trie_sequence_transcoder DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the block: registers, walker position and tables.
	logic [12:0] root_q;
	logic [13:0] ncount_q;
	logic [12:0] walk_node;
	logic [15:0] label_mem [NODES];
	node_t       link_mem [NODES];
	logic [12:0] slot_mem [CHILD_SLOTS];
	logic [15:0] word_mem [SEQ_WORDS];

	res_t pending_out[$];
	int   errors = 0;
	bit   gaps_on = 1'b1;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic res_t mk_res(input logic [20:0] code, input logic kind,
			input logic status, input logic [12:0] sidx);
		res_t r;
		r = '0;
		r.out_code = code;
		r.kind = kind;
		r.status = status;
		r.state_index = sidx;
		return r;
	endfunction

	// Scan a node's child slots for an edge labeled with code.
	task automatic match_child(input logic [12:0] node, input logic [20:0] code,
			output bit hit, output logic [12:0] child);
		int s;
		hit = 1'b0;
		child = '0;
		for (int i = 0; i < link_mem[node].cc; i++) begin
			s = link_mem[node].cf + i;
			if (s >= CHILD_SLOTS)
				break;
			if ({5'b0, label_mem[slot_mem[s]]} == code) begin
				hit = 1'b1;
				child = slot_mem[s];
				return;
			end
		end
	endtask

	// Pending output of a non-root node: replacement code, else its word sequence.
	task automatic emit_node(input logic [12:0] node, ref res_t q[$]);
		int n;
		int a;
		if (link_mem[node].repl != 16'd0) begin
			q.push_back(mk_res({5'b0, link_mem[node].repl}, 1'b0, 1'b0, '0));
			return;
		end
		n = (link_mem[node].sc > MAX_SEQ) ? int'(MAX_SEQ) : int'(link_mem[node].sc);
		for (int i = 0; i < n; i++) begin
			a = link_mem[node].sf + i;
			q.push_back(mk_res((a < SEQ_WORDS) ? {5'b0, word_mem[a]} : 21'd0,
				1'b0, 1'b0, '0));
		end
	endtask

	// Advance the shadow state by one transaction and queue its results.
	task automatic transcode(input cmd_t c);
		res_t        outs[$];
		bit          hit;
		bit          moved;
		logic [12:0] child;
		moved = 1'b0;
		case (c.mode)
			MODE_WR_NODE: begin
				label_mem[c.node_index] = c.code[15:0];
				link_mem[c.node_index] = '{repl: c.repl_code, cf: c.child_first,
					cc: c.child_count, sf: c.seq_first, sc: c.seq_count};
			end
			MODE_WR_SLOT: begin
				if (c.slot_index < CHILD_SLOTS)
					slot_mem[c.slot_index[12:0]] = c.node_index;
			end
			MODE_WR_SEQ: begin
				word_mem[c.slot_index] = c.code[15:0];
			end
			MODE_DECODE: begin
				if (walk_node != root_q) begin
					match_child(walk_node, c.code, hit, child);
					if (hit) begin
						walk_node = child;
						moved = 1'b1;
					end else begin
						emit_node(walk_node, outs);
						walk_node = root_q;
					end
				end
				// retry at the root after a miss deeper down
				if (!moved) begin
					match_child(walk_node, c.code, hit, child);
					if (hit)
						walk_node = child;
					else
						outs.push_back(mk_res(c.code, 1'b0, 1'b0, '0));
				end
			end
			MODE_FLUSH: begin
				if (walk_node != root_q)
					emit_node(walk_node, outs);
				walk_node = root_q;
			end
			MODE_SET: begin
				if ({1'b0, c.node_index} < ncount_q) begin
					outs.push_back(mk_res('0, 1'b1, 1'b0, walk_node));
					walk_node = c.node_index;
				end else begin
					outs.push_back(mk_res('0, 1'b1, 1'b1, walk_node));
				end
			end
			MODE_READ: begin
				outs.push_back(mk_res('0, 1'b1, 1'b0, walk_node));
			end
			default: ;
		endcase
		if (outs.size() > 0)
			outs[$].last = 1'b1;
		foreach (outs[i])
			pending_out.push_back(outs[i]);
	endtask

	// Results are strobed for one cycle; compare each against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid) begin
			if (pending_out.size() == 0) begin
				report("unexpected result", 32'(res.out_code), 32'd0);
			end else begin
				want = pending_out.pop_front();
				if (res.out_code !== want.out_code)
					report("out_code", 32'(res.out_code), 32'(want.out_code));
				if (res.last !== want.last)
					report("last", 32'(res.last), 32'(want.last));
				if (res.kind !== want.kind)
					report("kind", 32'(res.kind), 32'(want.kind));
				if (res.status !== want.status)
					report("status", 32'(res.status), 32'(want.status));
				if (res.state_index !== want.state_index)
					report("state_index", 32'(res.state_index), 32'(want.state_index));
			end
		end
	end

	// Mostly short gaps, occasionally a long one.
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one transaction and hold it until the block takes it.
	task automatic send(input cmd_t c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		transcode(c);
	endtask

	// Let the block drain: all results in, then no work left in flight.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == ADDR_ROOT) begin
			root_q = val[12:0];
			if (prdata[12:0] !== root_q)
				report("root_node readback", prdata, 32'(root_q));
		end else begin
			ncount_q = val[13:0];
			if (prdata[13:0] !== ncount_q)
				report("node_count readback", prdata, 32'(ncount_q));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cmd_t mk_cmd(input logic [2:0] mode, input logic [20:0] code,
			input logic [12:0] node, input logic [14:0] slot);
		cmd_t c;
		c = '0;
		c.mode = mode;
		c.code = code;
		c.node_index = node;
		c.slot_index = slot;
		return c;
	endfunction

	function automatic cmd_t mk_node(input logic [12:0] idx, input logic [15:0] label,
			input logic [15:0] repl, input logic [12:0] cf, input logic [7:0] cc,
			input logic [14:0] sf, input logic [3:0] sc);
		cmd_t c;
		c = mk_cmd(MODE_WR_NODE, {5'b0, label}, idx, '0);
		c.repl_code = repl;
		c.child_first = cf;
		c.child_count = cc;
		c.seq_first = sf;
		c.seq_count = sc;
		return c;
	endfunction

	// Labels and decoded code points share a small alphabet so walks go deep.
	function automatic logic [15:0] pick_label();
		return 16'(16'h61 + $urandom_range(0, 7));
	endfunction

	// Node whose links stay inside the pool.
	function automatic cmd_t pool_node(input int idx);
		int cf;
		int sf;
		cf = $urandom_range(0, POOL_SLOTS - 1);
		sf = $urandom_range(0, POOL_WORDS - MAX_SEQ);
		return mk_node(13'(idx), pick_label(),
			($urandom_range(0, 1) != 0) ? 16'h0 : 16'($urandom()),
			13'(cf), 8'($urandom_range(0, (POOL_SLOTS - cf < 4) ? POOL_SLOTS - cf : 4)),
			15'(sf), 4'($urandom_range(0, 15)));
	endfunction

	function automatic cmd_t pool_slot(input int idx);
		return mk_cmd(MODE_WR_SLOT, 21'($urandom()),
			13'($urandom_range(0, POOL_NODES - 1)), 15'(idx));
	endfunction

	function automatic cmd_t pool_word(input int idx);
		return mk_cmd(MODE_WR_SEQ, 21'($urandom()), 13'($urandom()), 15'(idx));
	endfunction

	// Fill every pool entry so any walk inside it reads loaded data.
	task automatic test_load_tables();
		for (int i = 0; i < POOL_WORDS; i++)
			send(pool_word(i));
		for (int i = 0; i < POOL_SLOTS; i++)
			send(pool_slot(i));
		for (int i = 0; i < POOL_NODES; i++)
			send(pool_node(i));
		wait_idle();
	endtask

	// Corner cases: table ends, saturated counts, wide codes, rejected set, idle modes.
	task automatic test_directed_edges();
		reg_write(ADDR_ROOT, 32'd0);
		reg_write(ADDR_NCOUNT, 32'd0);
		gaps_on = 1'b0;
		// only the low 16 bits of a sequence word are stored
		send(mk_cmd(MODE_WR_SEQ, 21'h1FABCD, 13'h1FFF, 15'h7FFF));
		send(mk_cmd(MODE_WR_SLOT, '0, 13'h1FFF, 15'd8190));
		send(mk_cmd(MODE_WR_SLOT, '0, 13'd1, 15'd8191));
		// slot beyond the child table is dropped
		send(mk_cmd(MODE_WR_SLOT, '0, 13'd5, 15'h7FFF));
		// last node: child scan runs off the slot table, sequence off the word store,
		// sequence length saturates
		send(mk_node(13'h1FFF, 16'hFFFF, 16'h0, 13'd8190, 8'hFF, 15'h7FFF, 4'hF));
		send(mk_node(13'd0, 16'h0, 16'h0, 13'd8190, 8'd2, 15'd0, 4'd1));
		send(mk_cmd(MODE_DECODE, 21'h0FFFF, '0, '0));
		// code above 16 bits never matches: full sequence plus echo
		send(mk_cmd(MODE_DECODE, 21'h1FFFFF, '0, '0));
		send(mk_cmd(MODE_DECODE, 21'h0FFFF, '0, '0));
		send(mk_cmd(MODE_FLUSH, '0, '0, '0));
		// flush at the root and the unused mode: no results
		send(mk_cmd(MODE_FLUSH, '0, '0, '0));
		send(mk_cmd(MODE_NONE, 21'h1FFFFF, 13'h1FFF, 15'h7FFF));
		// node_count of zero rejects every set
		send(mk_cmd(MODE_SET, '0, 13'd3, '0));
		wait_idle();
		reg_write(ADDR_NCOUNT, 32'd8192);
		gaps_on = 1'b1;
		send(mk_cmd(MODE_SET, '0, 13'h1FFF, '0));
		send(mk_cmd(MODE_READ, '0, '0, '0));
		send(mk_node(13'h1FFF, 16'hFFFF, 16'hFFFF, 13'd8190, 8'hFF, 15'h7FFF, 4'hF));
		send(mk_cmd(MODE_DECODE, 21'h10000, '0, '0));
		wait_idle();
		reg_write(ADDR_ROOT, 32'h1FFF);
		send(mk_cmd(MODE_READ, '0, '0, '0));
		send(mk_cmd(MODE_DECODE, 21'h61, '0, '0));
		send(mk_cmd(MODE_FLUSH, '0, '0, '0));
		wait_idle();
	endtask

	// Noise write aimed outside the pool and away from the last node and its slots.
	function automatic cmd_t noise_write();
		cmd_t c;
		c = cmd_t'({$urandom(), $urandom(), $urandom(), $urandom()});
		case ($urandom_range(0, 2))
			0: begin
				c.mode = MODE_WR_NODE;
				c.node_index = 13'($urandom_range(POOL_NODES, 8189));
			end
			1: begin
				c.mode = MODE_WR_SLOT;
				c.slot_index = ($urandom_range(0, 1) != 0) ?
					15'($urandom_range(POOL_SLOTS, 8189)) : 15'($urandom_range(8192, 32767));
			end
			default: begin
				c.mode = MODE_WR_SEQ;
				c.slot_index = 15'($urandom_range(POOL_WORDS, 32766));
			end
		endcase
		return c;
	endfunction

	// Random mix dominated by decodes over the pool trie.
	task automatic test_random_walks(input logic [12:0] root, input logic [13:0] ncount,
			input int count);
		int   r;
		cmd_t c;
		wait_idle();
		reg_write(ADDR_ROOT, 32'(root));
		reg_write(ADDR_NCOUNT, 32'(ncount));
		gaps_on = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				c = cmd_t'({$urandom(), $urandom(), $urandom(), $urandom()});
				c.mode = MODE_DECODE;
				if ($urandom_range(0, 9) != 0)
					c.code = {5'b0, pick_label()};
			end else if (r < 65) begin
				c = mk_cmd(MODE_FLUSH, 21'($urandom()), 13'($urandom()), 15'($urandom()));
			end else if (r < 73) begin
				c = mk_cmd(MODE_SET, '0, 13'($urandom_range(0, POOL_NODES - 1)), '0);
				// out-of-range requests only where they are surely rejected
				if (ncount <= POOL_NODES && $urandom_range(0, 1) != 0)
					c.node_index = 13'($urandom_range(POOL_NODES, 8191));
			end else if (r < 80) begin
				c = mk_cmd(MODE_READ, '0, '0, '0);
			end else if (r < 93) begin
				case ($urandom_range(0, 2))
					0: c = pool_node($urandom_range(0, POOL_NODES - 1));
					1: c = pool_slot($urandom_range(0, POOL_SLOTS - 1));
					default: c = pool_word($urandom_range(0, POOL_WORDS - 1));
				endcase
			end else if (r < 98) begin
				c = noise_write();
			end else begin
				c = mk_cmd(MODE_NONE, 21'($urandom()), '0, '0);
			end
			send(c);
		end
	endtask

	initial begin
		walk_node = '0;
		root_q = '0;
		ncount_q = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_tables();
		test_directed_edges();
		// node 0 was repointed by the directed part; restore it to the pool
		send(pool_node(0));
		test_random_walks(13'd0, 14'd16, 100);
		test_random_walks(13'd15, 14'd8192, 100);
		test_random_walks(13'd3, 14'd7, 100);
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/tst_pkg.sv
rtl/trie_sequence_transcoder.sv
rtl/tst_checker.sv
dv/trie_sequence_transcoder_test.sv
